[design/multi_queue_shared_buffer_top_defines.svh]
// Assertion macros used by the multi-queue shared buffer port checker.
`ifndef MULTI_QUEUE_SHARED_BUFFER_TOP_DEFINES_SVH
`define MULTI_QUEUE_SHARED_BUFFER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MQSB_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("mqsb: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define MQSB_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("mqsb: next-cycle check failed");

`endif

[design/mqsb_pkg.sv]
// Types, constants and state codes for the multi-queue shared buffer.
package mqsb_pkg;

	localparam int SLOTS_DEF  = 64;
	localparam int QUEUES_DEF = 8;
	localparam int QUEUE_ID_W = 3;
	localparam int DATA_W     = 32;
	localparam int STATUS_W   = 2;

	localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_OVERFLOW  = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_UNDERFLOW = 2'd2;

	localparam logic MODE_ENQ = 1'b0;
	localparam logic MODE_DEQ = 1'b1;

	typedef struct packed {
		logic                     mode;
		logic [QUEUE_ID_W-1:0]    queue_id;
		logic signed [DATA_W-1:0] data_in;
	} op_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] data_out;
		logic [STATUS_W-1:0]      status;
		logic                     store_full;
		logic                     queue_empty;
	} result_t;

	// Controller to datapath.
	typedef struct packed {
		logic capture;
		logic fetch;
		logic update;
	} ctrl_t;

	// Datapath to controller.
	typedef struct packed {
		logic dequeue;
		logic queue_nonempty;
	} stat_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOOK,
		ST_FETCH,
		ST_UPDATE
	} state_t;

endpackage

[design/multi_queue_shared_buffer_top.sv]
// Multi-queue shared buffer: several FIFO queues linked through one slot store.
// Steps: accept, LOOK, then UPDATE for an enqueue or an underflow; a dequeue that
//   returns data passes through FETCH before UPDATE. done is registered from UPDATE.
// The next transaction is accepted in the cycle the result shows; none is taken while
//   busy. FETCH is needed for the chain of registered RAM reads (head, then link).
// Reset: asynchronous; all queues empty, every slot free, ready at once, no clear sweep.
// Results are not back-pressured: done is a one-cycle strobe.
module multi_queue_shared_buffer_top #(
	parameter int SLOTS  = mqsb_pkg::SLOTS_DEF,
	parameter int QUEUES = mqsb_pkg::QUEUES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  mqsb_pkg::op_t     op,
	output logic              busy,
	output logic              done,
	output mqsb_pkg::result_t result
);

	// Command and status between sequencer and datapath.
	mqsb_pkg::ctrl_t ctrl;
	mqsb_pkg::stat_t stat;

	// Sequencer: IDLE -> LOOK -> (FETCH) -> UPDATE.
	// LOOK reads head/tail of the queue and the link of the free head;
	// FETCH reads link and value of the queue head for a dequeue;
	// UPDATE writes the tables back and loads the result register.
	mqsb_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.busy   (busy),
		.done   (done),
		.ctrl   (ctrl)
	);

	// Datapath: the slot store and link table live in RAM; emptiness of each
	// queue is kept in flops, and a fill mark stands in for the reset value of
	// links that were never written, so no clearing pass is needed.
	mqsb_datapath #(.SLOTS(SLOTS), .QUEUES(QUEUES)) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.op     (op),
		.ctrl   (ctrl),
		.stat   (stat),
		.result (result)
	);

endmodule

[design/mqsb_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module mqsb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[design/mqsb_ctrl.sv]
// Controller state machine for the multi-queue shared buffer.
module mqsb_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  mqsb_pkg::stat_t stat,
	output logic            busy,
	output logic            done,
	output mqsb_pkg::ctrl_t ctrl
);

	mqsb_pkg::state_t state_q, state_d;
	logic             done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mqsb_pkg::ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= ctrl.update;
		end
	end

	always_comb begin
		state_d      = state_q;
		ctrl.capture = 1'b0;
		ctrl.fetch   = 1'b0;
		ctrl.update  = 1'b0;
		busy         = 1'b1;
		unique case (state_q)
			mqsb_pkg::ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					ctrl.capture = 1'b1;
					state_d      = mqsb_pkg::ST_LOOK;
				end
			end
			mqsb_pkg::ST_LOOK: begin
				// only a dequeue from a live queue needs the second read
				if (stat.dequeue && stat.queue_nonempty) begin
					state_d = mqsb_pkg::ST_FETCH;
				end else begin
					state_d = mqsb_pkg::ST_UPDATE;
				end
			end
			mqsb_pkg::ST_FETCH: begin
				ctrl.fetch = 1'b1;
				state_d    = mqsb_pkg::ST_UPDATE;
			end
			mqsb_pkg::ST_UPDATE: begin
				ctrl.update = 1'b1;
				state_d     = mqsb_pkg::ST_IDLE;
			end
			default: begin
				state_d = mqsb_pkg::ST_IDLE;
			end
		endcase
	end

	assign done = done_q;

endmodule

[design/mqsb_datapath.sv]
// Datapath: slot store, link table, queue head/tail tables and free list.
module mqsb_datapath #(
	parameter int SLOTS  = mqsb_pkg::SLOTS_DEF,
	parameter int QUEUES = mqsb_pkg::QUEUES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  mqsb_pkg::op_t     op,
	input  mqsb_pkg::ctrl_t   ctrl,
	output mqsb_pkg::stat_t   stat,
	output mqsb_pkg::result_t result
);

	localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;   // slot index
	localparam int PW = $clog2(SLOTS + 1);                  // pointer, SLOTS = null
	localparam int QW = (QUEUES > 1) ? $clog2(QUEUES) : 1;
	localparam int DW = mqsb_pkg::DATA_W;

	// queue_id folded into range; queue_id is only QUEUE_ID_W (3) bits wide
	function automatic logic [QW-1:0] qmod(input logic [mqsb_pkg::QUEUE_ID_W-1:0] id);
		int v;
		v = int'(id);
		for (int i = 0; i < (1 << mqsb_pkg::QUEUE_ID_W); i++) begin
			if (v >= QUEUES) begin
				v = v - QUEUES;
			end
		end
		return QW'(v);
	endfunction

	logic              mode_q;
	logic [QW-1:0]     q_q;
	logic [DW-1:0]     data_q;
	logic [PW-1:0]     free_q, free_d;
	logic [PW-1:0]     fill_q, fill_d;   // slots at or above this were never allocated
	logic [QUEUES-1:0] ne_q;             // per-queue nonempty
	mqsb_pkg::result_t result_q, result_d;

	logic [SW-1:0] head_rd, tail_rd;
	logic [PW-1:0] link_rd;
	logic [DW-1:0] value_rd;

	logic          full_now, nonempty, fresh, last, do_enq, do_deq, ne_after;
	logic          head_we, link_we;
	logic [SW-1:0] head_wdata, link_waddr, link_raddr;
	logic [PW-1:0] next_free_enq;

	always_ff @(posedge clk) begin
		if (ctrl.capture) begin
			mode_q <= op.mode;
			q_q    <= qmod(op.queue_id);
			data_q <= op.data_in;
		end
		if (ctrl.update) begin
			result_q <= result_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_q <= '0;
			fill_q <= '0;
			ne_q   <= '0;
		end else if (ctrl.update) begin
			free_q     <= free_d;
			fill_q     <= fill_d;
			ne_q[q_q]  <= ne_after;
		end
	end

	always_comb begin
		full_now      = (free_q == PW'(SLOTS));
		nonempty      = ne_q[q_q];
		fresh         = (free_q >= fill_q);
		last          = (head_rd == tail_rd);
		do_enq        = ctrl.update && (mode_q == mqsb_pkg::MODE_ENQ) && !full_now;
		do_deq        = ctrl.update && (mode_q == mqsb_pkg::MODE_DEQ) && nonempty;
		// an untouched slot still holds its reset link, the next slot up
		next_free_enq = fresh ? (free_q + PW'(1)) : link_rd;

		head_we    = (do_enq && !nonempty) || (do_deq && !last);
		head_wdata = do_deq ? link_rd[SW-1:0] : free_q[SW-1:0];
		link_we    = (do_enq && nonempty) || do_deq;
		link_waddr = do_deq ? head_rd : tail_rd;
		link_raddr = ctrl.fetch ? head_rd : free_q[SW-1:0];

		if (do_enq) begin
			free_d = next_free_enq;
		end else if (do_deq) begin
			free_d = PW'(head_rd);
		end else begin
			free_d = free_q;
		end
		fill_d = (do_enq && fresh) ? (free_q + PW'(1)) : fill_q;

		if (do_enq) begin
			ne_after = 1'b1;
		end else if (do_deq && last) begin
			ne_after = 1'b0;
		end else begin
			ne_after = nonempty;
		end

		result_d.data_out    = do_deq ? value_rd : '0;
		result_d.store_full  = (free_d == PW'(SLOTS));
		result_d.queue_empty = !ne_after;
		if ((mode_q == mqsb_pkg::MODE_ENQ) && full_now) begin
			result_d.status = mqsb_pkg::STATUS_OVERFLOW;
		end else if ((mode_q == mqsb_pkg::MODE_DEQ) && !nonempty) begin
			result_d.status = mqsb_pkg::STATUS_UNDERFLOW;
		end else begin
			result_d.status = mqsb_pkg::STATUS_OK;
		end
	end

	mqsb_ram #(.WIDTH(DW), .DEPTH(SLOTS)) u_values (
		.clk   (clk),
		.we    (do_enq),
		.waddr (free_q[SW-1:0]),
		.wdata (data_q),
		.raddr (head_rd),
		.rdata (value_rd)
	);

	mqsb_ram #(.WIDTH(PW), .DEPTH(SLOTS)) u_links (
		.clk   (clk),
		.we    (link_we),
		.waddr (link_waddr),
		.wdata (free_q),
		.raddr (link_raddr),
		.rdata (link_rd)
	);

	mqsb_ram #(.WIDTH(SW), .DEPTH(QUEUES)) u_heads (
		.clk   (clk),
		.we    (head_we),
		.waddr (q_q),
		.wdata (head_wdata),
		.raddr (q_q),
		.rdata (head_rd)
	);

	mqsb_ram #(.WIDTH(SW), .DEPTH(QUEUES)) u_tails (
		.clk   (clk),
		.we    (do_enq),
		.waddr (q_q),
		.wdata (free_q[SW-1:0]),
		.raddr (q_q),
		.rdata (tail_rd)
	);

	assign stat.dequeue        = (mode_q == mqsb_pkg::MODE_DEQ);
	assign stat.queue_nonempty = nonempty;
	assign result              = result_q;

endmodule

[design/mqsb_checker.sv]
// Port-level checker for the multi-queue shared buffer, bound to the top level.
`include "multi_queue_shared_buffer_top_defines.svh"

module mqsb_port_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input logic              done,
	input mqsb_pkg::result_t result
);

	logic ovf_strobe;
	logic udf_strobe;
	logic udf_reply;

	assign ovf_strobe = done && (result.status == mqsb_pkg::STATUS_OVERFLOW);
	assign udf_strobe = done && (result.status == mqsb_pkg::STATUS_UNDERFLOW);
	assign udf_reply  = result.queue_empty && (result.data_out == '0);

	`MQSB_ASSERT_NXT(a_accept_busy, clk, arst_n, start && !busy, busy)
	`MQSB_ASSERT_IMP(a_done_after_busy, clk, arst_n, done, $past(busy) && !busy)
	`MQSB_ASSERT_IMP(a_overflow_full, clk, arst_n, ovf_strobe, result.store_full)
	`MQSB_ASSERT_IMP(a_underflow_empty, clk, arst_n, udf_strobe, udf_reply)

endmodule

bind multi_queue_shared_buffer_top mqsb_port_checker u_mqsb_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.result (result)
);

[tb/mqsb_checker.sv]
// Checker for the multi-queue shared buffer: predicts every transaction and compares results.
module mqsb_checker
	import mqsb_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	input  logic    busy,
	input  op_t     op,
	input  logic    done,
	input  result_t result,
	output int      fail_count,
	output int      awaited,
	output int      checked,
	output int      overflows,
	output int      underflows
);

	localparam int NIL = SLOTS_DEF;

	// Shadow of the slot store, its link table and the queue pointers.
	logic [DATA_W-1:0] slot_data [SLOTS_DEF];
	int                slot_next [SLOTS_DEF];
	int                q_head    [QUEUES_DEF];
	int                q_tail    [QUEUES_DEF];
	int                free_ptr;

	result_t pending_replies [$];
	int      fails;
	int      n_checked;
	int      n_ovf;
	int      n_udf;

	initial begin
		for (int i = 0; i < SLOTS_DEF; i++) begin
			slot_data[i] = '0;
			slot_next[i] = i + 1;
		end
		for (int i = 0; i < QUEUES_DEF; i++) begin
			q_head[i] = NIL;
			q_tail[i] = 0;
		end
		free_ptr   = 0;
		fails      = 0;
		n_checked  = 0;
		n_ovf      = 0;
		n_udf      = 0;
		fail_count = 0;
		awaited    = 0;
		checked    = 0;
		overflows  = 0;
		underflows = 0;
	end

	// Applies one transaction to the shadow state and returns the result it must give.
	function automatic result_t apply_queue_op(input op_t item);
		result_t r;
		int      q;
		int      s;
		q = int'(item.queue_id) % QUEUES_DEF;
		r = '0;
		r.status = STATUS_OK;
		if (item.mode == MODE_ENQ) begin
			if (free_ptr == NIL) begin
				r.status = STATUS_OVERFLOW;
			end else begin
				s = free_ptr;
				free_ptr = slot_next[s];
				if (q_head[q] == NIL) begin
					q_head[q] = s;
				end else begin
					slot_next[q_tail[q]] = s;
				end
				slot_next[s] = NIL;
				q_tail[q]    = s;
				slot_data[s] = item.data_in;
			end
		end else begin
			s = q_head[q];
			if (s == NIL) begin
				r.status = STATUS_UNDERFLOW;
			end else begin
				q_head[q]    = slot_next[s];
				slot_next[s] = free_ptr;
				free_ptr     = s;
				r.data_out   = slot_data[s];
			end
		end
		r.store_full  = (free_ptr == NIL);
		r.queue_empty = (q_head[q] == NIL);
		return r;
	endfunction

	always @(posedge clk) begin
		result_t want;
		if (arst_n) begin
			// Compare first: a new transaction can be accepted on the edge that ends a result.
			if (done) begin
				if (pending_replies.size() == 0) begin
					fails++;
					if (fails <= 10)
						$display("Unexpected result: data=%h status=%0d full=%b empty=%b",
							result.data_out, result.status, result.store_full,
							result.queue_empty);
				end else begin
					want = pending_replies.pop_front();
					n_checked++;
					if (result.data_out !== want.data_out || result.status !== want.status ||
							result.store_full !== want.store_full ||
							result.queue_empty !== want.queue_empty) begin
						fails++;
						if (fails <= 10)
							$display({"Result mismatch: want data=%h status=%0d full=%b empty=%b,",
								" got data=%h status=%0d full=%b empty=%b"},
								want.data_out, want.status, want.store_full, want.queue_empty,
								result.data_out, result.status, result.store_full,
								result.queue_empty);
					end
				end
			end
			if (start && !busy) begin
				want = apply_queue_op(op);
				if (want.status == STATUS_OVERFLOW)
					n_ovf++;
				if (want.status == STATUS_UNDERFLOW)
					n_udf++;
				pending_replies.push_back(want);
			end
		end
		fail_count <= fails;
		awaited    <= pending_replies.size();
		checked    <= n_checked;
		overflows  <= n_ovf;
		underflows <= n_udf;
	end

endmodule

[tb/tb_multi_queue_shared_buffer_top.sv]
// Testbench top for the multi-queue shared buffer: clock, reset, stimulus and verdict.
module tb_multi_queue_shared_buffer_top;
	import mqsb_pkg::*;

	// Far above the slowest correct run (about 1620 transactions, with the sender
	// idle 80 percent of the time in one phase).
	localparam int LIMIT = 500000;

	logic    clk    = 1'b0;
	logic    arst_n = 1'b0;
	logic    start  = 1'b0;
	op_t     op     = '0;
	logic    busy;
	logic    done;
	result_t result;

	int fail_count;
	int awaited;
	int checked;
	int overflows;
	int underflows;

	int idle_pct = 0;  // chance per cycle that the sender holds start low
	int cycles   = 0;
	int issued   = 0;

	always #2 clk = ~clk;

	multi_queue_shared_buffer_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.op     (op),
		.busy   (busy),
		.done   (done),
		.result (result)
	);

	// Watches both channels, predicts each transaction and counts failures.
	mqsb_checker u_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.op         (op),
		.done       (done),
		.result     (result),
		.fail_count (fail_count),
		.awaited    (awaited),
		.checked    (checked),
		.overflows  (overflows),
		.underflows (underflows)
	);

	// Watchdog: a hang or a lost result ends the run here.
	always @(posedge clk) begin
		cycles++;
		if (cycles >= LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	function automatic op_t make_op(input logic mode, input int q, input logic [DATA_W-1:0] d);
		op_t o;
		o.mode     = mode;
		o.queue_id = QUEUE_ID_W'(q);
		o.data_in  = d;
		return o;
	endfunction

	// Offers one transaction until it is taken. The sender drops start at random on any
	// cycle, busy or not, so gaps land on every stage of the block's work.
	task automatic issue(input op_t item);
		bit taken;
		taken = 1'b0;
		while (!taken) begin
			if ($urandom_range(99) < idle_pct) begin
				start <= 1'b0;
			end else begin
				start <= 1'b1;
				op    <= item;
			end
			@(posedge clk);
			taken = start && !busy;
		end
		issued++;
	endtask

	// Sender holds off until every predicted result has come back.
	task automatic wait_quiet();
		start <= 1'b0;
		@(posedge clk);
		while (awaited != 0)
			@(posedge clk);
	endtask

	// Random traffic in bursts. Each burst leans toward filling, draining or balance and
	// targets a window of queues, so the shared store swings between empty and full and
	// dequeues mostly find data.
	task automatic run_phase(input int count, input int pct);
		int left;
		int burst;
		int enq_pct;
		int base;
		int span;
		idle_pct = pct;
		left     = count;
		while (left > 0) begin
			burst = $urandom_range(64, 16);
			if (burst > left)
				burst = left;
			case ($urandom_range(2))
				0: enq_pct = 90;
				1: enq_pct = 50;
				default: enq_pct = 15;
			endcase
			base = $urandom_range(7);
			span = $urandom_range(7);
			for (int i = 0; i < burst; i++)
				issue(make_op(($urandom_range(99) < enq_pct) ? MODE_ENQ : MODE_DEQ,
					base + $urandom_range(span), $urandom()));
			left -= burst;
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: underflow on empty queues, data extremes, both end queues,
		// FIFO order within a queue, and a dequeue whose data field must be ignored.
		idle_pct = 0;
		issue(make_op(MODE_DEQ, 0, 32'h0000_0000));
		issue(make_op(MODE_DEQ, 7, 32'hFFFF_FFFF));
		issue(make_op(MODE_ENQ, 0, 32'h7FFF_FFFF));
		issue(make_op(MODE_ENQ, 0, 32'h8000_0000));
		issue(make_op(MODE_ENQ, 7, 32'h0000_0000));
		issue(make_op(MODE_ENQ, 7, 32'hFFFF_FFFF));
		issue(make_op(MODE_ENQ, 3, 32'h5555_5555));
		issue(make_op(MODE_ENQ, 4, 32'hAAAA_AAAA));
		issue(make_op(MODE_DEQ, 0, 32'h1234_5678));
		issue(make_op(MODE_DEQ, 0, 32'h0000_0000));
		issue(make_op(MODE_DEQ, 0, 32'h0000_0000));
		issue(make_op(MODE_DEQ, 7, 32'h0000_0000));
		issue(make_op(MODE_DEQ, 7, 32'h0000_0000));
		issue(make_op(MODE_DEQ, 3, 32'h0000_0000));
		issue(make_op(MODE_DEQ, 4, 32'h0000_0000));
		issue(make_op(MODE_DEQ, 4, 32'h0000_0000));
		issue(make_op(MODE_DEQ, 5, 32'hDEAD_BEEF));
		wait_quiet();

		// Fill sweep: more enqueues than slots, so the store fills and overflows,
		// then ten dequeues on every queue.
		for (int i = 0; i < 70; i++)
			issue(make_op(MODE_ENQ, $urandom_range(7), $urandom()));
		for (int q = 0; q < QUEUES_DEF; q++)
			for (int k = 0; k < 10; k++)
				issue(make_op(MODE_DEQ, q, $urandom()));
		wait_quiet();

		// Random phases: no idling, sender idle 80 percent, idle 32 percent, no idling.
		// The block cannot be held off on the result side.
		run_phase(350, 0);
		wait_quiet();
		run_phase(400, 80);
		wait_quiet();
		run_phase(400, 32);
		wait_quiet();
		run_phase(300, 0);
		wait_quiet();

		// Let any stray strobe show up before the verdict.
		repeat (8) @(posedge clk);

		$display("Ran %0d transactions over four sender idle settings (0, 80, 32, 0 percent).",
			issued);
		$display("Checked %0d results, including %0d overflows and %0d underflows.",
			checked, overflows, underflows);
		if (fail_count == 0 && awaited == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
